// ===== rtl/ccfd_pkg.sv =====
// Package for the CRC-checked frame deframer: configuration and frame record types,
// type-code and register-index constants, and the byte-wise reflected CRC function.
// No dependencies.
package ccfd_pkg;

   localparam int FRAME_BYTES_DEF = 14;
   // payload bytes that results are built from: frame bytes 1 .. 12
   localparam int STORE_BYTES = 12;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JOYSTICK_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_CODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEARTBEAT_CODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENT_CODE     = 3'd5;

   localparam logic [7:0] START_BYTE_RST     = 8'hAA;
   localparam logic [7:0] CRC_POLY_RST       = 8'h91;
   localparam logic [7:0] JOYSTICK_CODE_RST  = 8'h01;
   localparam logic [7:0] BUTTON_CODE_RST    = 8'h02;
   localparam logic [7:0] HEARTBEAT_CODE_RST = 8'h03;
   localparam logic [7:0] IDENT_CODE_RST     = 8'h04;

   typedef enum logic [1:0] {
      KIND_JOYSTICK  = 2'd0,
      KIND_BUTTON    = 2'd1,
      KIND_HEARTBEAT = 2'd2,
      KIND_IDENT     = 2'd3
   } frame_kind_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] crc_poly;
      logic [7:0] joystick_code;
      logic [7:0] button_code;
      logic [7:0] heartbeat_code;
      logic [7:0] ident_code;
   } cfg_type;

   // body[k] holds frame byte k+1
   typedef struct packed {
      frame_kind_type                  kind;
      logic [STORE_BYTES-1:0][7:0]     body;
   } frame_rec_type;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = c ^ poly;
         c = c >> 1;
      end
      return c;
   endfunction

endpackage

// ===== rtl/ccfd_front.sv =====
// Front end of the deframer: start hunt, byte counting, running CRC, payload capture
// and frame classification. Emits one frame record per good frame of a known type.
// Depends on ccfd_pkg.
module ccfd_front #(
   parameter int FRAME_BYTES = ccfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_take,
   input  logic [7:0]             rx_byte,
   input  ccfd_pkg::cfg_type      cfg,
   output logic                   rec_valid,
   output ccfd_pkg::frame_rec_type rec
);
   import ccfd_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BYTES);
   localparam logic [CNT_W-1:0] LAST_DATA = CNT_W'(FRAME_BYTES - 1);

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       store_ff [STORE_BYTES];
   logic [7:0]       crc_next;
   logic             known;
   frame_kind_type   kind;
   logic             check_beat;

   assign crc_next   = crc_step(in_frame_ff ? crc_ff : 8'h00, rx_byte, cfg.crc_poly);
   assign check_beat = byte_take && in_frame_ff && (count_ff >= LAST_DATA);

   // first match wins when type codes collide
   always_comb begin
      known = 1'b1;
      kind  = KIND_JOYSTICK;
      if (store_ff[0] == cfg.joystick_code)       kind = KIND_JOYSTICK;
      else if (store_ff[0] == cfg.button_code)    kind = KIND_BUTTON;
      else if (store_ff[0] == cfg.heartbeat_code) kind = KIND_HEARTBEAT;
      else if (store_ff[0] == cfg.ident_code)     kind = KIND_IDENT;
      else                                        known = 1'b0;
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      if (byte_take) begin
         if (!in_frame_ff) begin
            if (rx_byte == cfg.start_byte) begin
               in_frame_in = 1'b1;
               count_in    = CNT_W'(1);
               crc_in      = crc_next;
            end
         end else if (count_ff < LAST_DATA) begin
            count_in = count_ff + CNT_W'(1);
            crc_in   = crc_next;
         end else begin
            in_frame_in = 1'b0;
            count_in    = '0;
            crc_in      = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         crc_ff      <= 8'h00;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
         if (byte_take && in_frame_ff && count_ff < LAST_DATA &&
             count_ff == CNT_W'(i + 1))
            store_ff[i] <= rx_byte;
      end
   end

   assign rec_valid = check_beat && (rx_byte == crc_ff) && known;

   always_comb begin
      rec.kind = kind;
      for (int i = 0; i < STORE_BYTES; i++) rec.body[i] = store_ff[i];
   end

endmodule

// ===== rtl/ccfd_queue.sv =====
// Short queue of frame records between front and back ends.
// Depends on ccfd_pkg.
module ccfd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ccfd_pkg::frame_rec_type push_rec,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output ccfd_pkg::frame_rec_type head_rec
);
   import ccfd_pkg::*;

   localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);
   localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QDEPTH - 1);

   frame_rec_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full      = (cnt_ff == QFULL);
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_rec  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) wptr_in = (wptr_ff == QLAST) ? '0 : wptr_ff + QPTR_W'(1);
      if (do_pop)  rptr_in = (rptr_ff == QLAST) ? '0 : rptr_ff + QPTR_W'(1);
      if (do_push && !do_pop)      cnt_in = cnt_ff + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wptr_ff] <= push_rec;
   end

endmodule

// ===== rtl/ccfd_back.sv =====
// Back end: unpacks a frame record into result words by kind and holds the result
// in an output register until popped. Depends on ccfd_pkg.
module ccfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rec_avail,
   input  ccfd_pkg::frame_rec_type rec,
   output logic                    rec_take,
   input  logic                    out_pop,
   output logic                    out_valid,
   output logic [1:0]              frame_kind,
   output logic [15:0]             word0,
   output logic [15:0]             word1,
   output logic [15:0]             word2,
   output logic [15:0]             word3,
   output logic [15:0]             word4,
   output logic [7:0]              word5
);
   import ccfd_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [15:0] w0_ff, w1_ff, w2_ff, w3_ff, w4_ff;
   logic [7:0]  w5_ff;
   logic [15:0] w0_in, w1_in, w2_in, w3_in, w4_in;
   logic [7:0]  w5_in;

   // output register free now or freed by this beat's pop
   assign rec_take = rec_avail && (!valid_ff || out_pop);

   always_comb begin
      valid_in = valid_ff;
      if (rec_take)      valid_in = 1'b1;
      else if (out_pop)  valid_in = 1'b0;
   end

   always_comb begin
      w0_in = '0;
      w1_in = '0;
      w2_in = '0;
      w3_in = '0;
      w4_in = '0;
      w5_in = '0;
      unique case (rec.kind)
         KIND_JOYSTICK: begin
            w0_in = {rec.body[1], rec.body[2]};
            w1_in = {rec.body[3], rec.body[4]};
            w2_in = {rec.body[5], rec.body[6]};
            w3_in = {rec.body[7], rec.body[8]};
            w4_in = {rec.body[9], rec.body[10]};
            w5_in = rec.body[11];
         end
         KIND_BUTTON: begin
            w0_in = {8'h00, rec.body[1]};
            w1_in = {8'h00, rec.body[2]};
            w2_in = {8'h00, rec.body[3]};
         end
         KIND_HEARTBEAT: begin
            w0_in = {8'h00, rec.body[1]};
         end
         KIND_IDENT: begin
            w0_in = {8'h00, rec.body[1]};
            w1_in = {8'h00, rec.body[2]};
            w2_in = {8'h00, rec.body[3]};
            w3_in = {8'h00, rec.body[4]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (rec_take) begin
         kind_ff <= rec.kind;
         w0_ff   <= w0_in;
         w1_ff   <= w1_in;
         w2_ff   <= w2_in;
         w3_ff   <= w3_in;
         w4_ff   <= w4_in;
         w5_ff   <= w5_in;
      end
   end

   assign out_valid  = valid_ff;
   assign frame_kind = kind_ff;
   assign word0      = w0_ff;
   assign word1      = w1_ff;
   assign word2      = w2_ff;
   assign word3      = w3_ff;
   assign word4      = w4_ff;
   assign word5      = w5_ff;

endmodule

// ===== rtl/crc_checked_frame_deframer.sv =====
// Top level of the CRC-checked frame deframer: configuration registers, front end,
// record queue and back end. Depends on ccfd_pkg, ccfd_front, ccfd_queue, ccfd_back.
//
//   channel  direction  handshake          payload
//   req      in         req_push/req_full  req_rx_byte
//   rsp      out        rsp_pop/rsp_empty  rsp_frame_kind, rsp_word0 .. rsp_word5
//   csr      in         csr_we             csr_index, csr_wdata
//
// One byte per cycle while req_full is low; the CRC of a byte is folded in the
// cycle it is taken. A good frame's record is pushed into the record queue as
// its check byte is taken, then moves to the output register that drives rsp
// once free. Up to two more can wait in it; req_full rises only while it is full.
// Synchronous active-high reset; no clearing pass is needed.
module crc_checked_frame_deframer #(
   parameter int FRAME_BYTES = ccfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [1:0]                        rsp_frame_kind,
   output logic [15:0]                       rsp_word0,
   output logic [15:0]                       rsp_word1,
   output logic [15:0]                       rsp_word2,
   output logic [15:0]                       rsp_word3,
   output logic [15:0]                       rsp_word4,
   output logic [7:0]                        rsp_word5,
   input  logic                              csr_we,
   input  logic [ccfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                        csr_wdata
);
   import ccfd_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          byte_take;
   logic          rec_valid;
   frame_rec_type front_rec;
   frame_rec_type head_rec;
   logic          q_full, q_not_empty, q_pop;
   logic          out_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_BYTE:     cfg_in.start_byte     = csr_wdata;
            CSR_CRC_POLY:       cfg_in.crc_poly       = csr_wdata;
            CSR_JOYSTICK_CODE:  cfg_in.joystick_code  = csr_wdata;
            CSR_BUTTON_CODE:    cfg_in.button_code    = csr_wdata;
            CSR_HEARTBEAT_CODE: cfg_in.heartbeat_code = csr_wdata;
            CSR_IDENT_CODE:     cfg_in.ident_code     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte     <= START_BYTE_RST;
         cfg_ff.crc_poly       <= CRC_POLY_RST;
         cfg_ff.joystick_code  <= JOYSTICK_CODE_RST;
         cfg_ff.button_code    <= BUTTON_CODE_RST;
         cfg_ff.heartbeat_code <= HEARTBEAT_CODE_RST;
         cfg_ff.ident_code     <= IDENT_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full  = q_full;
   assign byte_take = req_push && !q_full;

   ccfd_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .rec_valid (rec_valid),
      .rec       (front_rec)
   );

   ccfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_valid),
      .push_rec  (front_rec),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_rec  (head_rec)
   );

   ccfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rec_avail  (q_not_empty),
      .rec        (head_rec),
      .rec_take   (q_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .frame_kind (rsp_frame_kind),
      .word0      (rsp_word0),
      .word1      (rsp_word1),
      .word2      (rsp_word2),
      .word3      (rsp_word3),
      .word4      (rsp_word4),
      .word5      (rsp_word5)
   );

   assign rsp_empty = !out_valid;

endmodule
